/* rtl/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int MAX_RESULTS = 8;

    localparam int LEN_W  = 4;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W  = $clog2(MAX_RESULTS);
    localparam int HELD_W = $clog2(MAX_PATTERN);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_FIND_PATTERN   = 2'd0;
    localparam logic [1:0] REG_FIND_LENGTH    = 2'd1;
    localparam logic [1:0] REG_REPLACE_TEXT   = 2'd2;
    localparam logic [1:0] REG_REPLACE_LENGTH = 2'd3;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [DATA_W-1:0] find_pattern;
        logic [LEN_W-1:0]  find_length;
        logic [DATA_W-1:0] replace_text;
        logic [LEN_W-1:0]  replace_length;
    } cfg_t;

    // One entry of the work queue: the result beats caused by one input item.
    typedef struct packed {
        byte_t [MAX_RESULTS-1:0] data;
        logic [CNT_W-1:0]        count;
        logic                    has_bytes;
        logic                    err;
        logic                    done;
    } job_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] max_len);
        sat_len = (len > max_len) ? max_len : len;
    endfunction

endpackage

`default_nettype wire

/* rtl/sfr_regs.sv */
// Configuration register file with its APB-style access port.
// Depends on sfr_pkg for the register indexes and the cfg_t type.
`default_nettype none

module sfr_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic      [sfr_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output sfr_pkg::cfg_t                   cfg,
    output logic                            held_clear
);
    import sfr_pkg::*;

    logic [DATA_W-1:0] find_pattern_reg;
    logic [LEN_W-1:0]  find_length_reg;
    logic [DATA_W-1:0] replace_text_reg;
    logic [LEN_W-1:0]  replace_length_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite;

    // A new pattern invalidates whatever partial match is being held.
    assign held_clear = wr_en &&
                        (reg_idx == REG_FIND_PATTERN || reg_idx == REG_FIND_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_pattern_reg   <= '0;
            find_length_reg    <= LEN_W'(1);
            replace_text_reg   <= '0;
            replace_length_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FIND_PATTERN:   find_pattern_reg   <= pwdata;
                REG_FIND_LENGTH:    find_length_reg    <= pwdata[LEN_W-1:0];
                REG_REPLACE_TEXT:   replace_text_reg   <= pwdata;
                REG_REPLACE_LENGTH: replace_length_reg <= pwdata[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FIND_PATTERN:   prdata = find_pattern_reg;
            REG_FIND_LENGTH:    prdata = DATA_W'(find_length_reg);
            REG_REPLACE_TEXT:   prdata = replace_text_reg;
            REG_REPLACE_LENGTH: prdata = DATA_W'(replace_length_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.find_pattern   = find_pattern_reg;
    assign cfg.find_length    = find_length_reg;
    assign cfg.replace_text   = replace_text_reg;
    assign cfg.replace_length = replace_length_reg;

endmodule

`default_nettype wire

/* rtl/sfr_front.sv */
// Front end: holds the pending partial match and turns each accepted input
// beat into one queue entry (or none). Depends on sfr_pkg.
`default_nettype none

module sfr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sfr_pkg::cfg_t cfg,
    input  wire logic          held_clear,
    input  wire logic          in_accept,
    input  wire logic [7:0]    text_byte,
    input  wire logic          byte_present,
    input  wire logic          text_end,
    output logic               push,
    output sfr_pkg::job_t      job
);
    import sfr_pkg::*;

    byte_t [MAX_PATTERN-1:0] held_reg, held_next;
    logic [HELD_W-1:0]       held_cnt_reg, held_cnt_next;
    logic [HELD_W-1:0]       hc;
    logic [CNT_W-1:0]        plen, rlen, n, drop, out_cnt;
    byte_t [MAX_PATTERN-1:0] buf_b, shifted;
    logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] eq;
    logic [MAX_PATTERN:0]    cand;
    logic                    full_match;
    logic                    ok;
    logic                    push_c;

    assign plen = sat_len(cfg.find_length, LEN_W'(MAX_PATTERN));
    assign rlen = sat_len(cfg.replace_length, LEN_W'(MAX_REPLACE));
    assign hc   = ({1'b0, held_cnt_reg} >= plen) ? '0 : held_cnt_reg;
    assign n    = {1'b0, hc} + CNT_W'(byte_present);

    // Candidate window: held bytes followed by the new byte.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            buf_b[i] = (CNT_W'(i) < {1'b0, hc}) ? held_reg[i] : text_byte;
        end
    end

    // eq[d][j]: window byte d+j equals pattern byte j.
    always_comb
    begin
        for (int d = 0; d < MAX_PATTERN; d++)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (d + j < MAX_PATTERN)
                    eq[d][j] = (buf_b[d+j] == cfg.find_pattern[8*j +: 8]);
                else
                    eq[d][j] = 1'b0;
            end
        end
    end

    // cand[d]: the window with its first d bytes dropped is still a proper
    // prefix of the pattern. Dropping everything always qualifies.
    always_comb
    begin
        for (int d = 0; d <= MAX_PATTERN; d++)
        begin
            ok = (CNT_W'(d) <= n) && ((n - CNT_W'(d)) < plen);
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (CNT_W'(j) < n - CNT_W'(d))
                begin
                    if (d + j < MAX_PATTERN)
                        ok = ok & eq[d][j];
                    else
                        ok = 1'b0;
                end
            end
            cand[d] = ok;
        end
    end

    always_comb
    begin
        full_match = byte_present && (n == plen);
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (CNT_W'(j) < n)
                full_match = full_match & eq[0][j];
        end
    end

    always_comb
    begin
        drop = n;
        for (int d = MAX_PATTERN; d >= 0; d--)
        begin
            if (cand[d])
                drop = CNT_W'(d);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            shifted[i] = '0;
            for (int d = 0; d < MAX_PATTERN; d++)
            begin
                if (drop == CNT_W'(d) && i + d < MAX_PATTERN)
                    shifted[i] = buf_b[i+d];
            end
        end
    end

    always_comb
    begin
        job           = '0;
        job.done      = text_end;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        out_cnt       = '0;
        push_c        = 1'b0;
        if (plen == '0)
        begin
            // Empty pattern: report it, touch nothing.
            job.err   = 1'b1;
            job.count = CNT_W'(1);
            push_c    = 1'b1;
        end
        else
        begin
            held_cnt_next = hc;
            if (full_match)
            begin
                job.data      = cfg.replace_text;
                out_cnt       = rlen;
                held_cnt_next = '0;
            end
            else if (byte_present)
            begin
                // With end of text the kept bytes follow the released ones,
                // so the whole window goes out.
                job.data      = buf_b;
                out_cnt       = text_end ? n : drop;
                held_next     = shifted;
                held_cnt_next = text_end ? '0 : HELD_W'(n - drop);
            end
            else
            begin
                job.data = buf_b;
                out_cnt  = text_end ? {1'b0, hc} : '0;
                if (text_end)
                    held_cnt_next = '0;
            end

            if (out_cnt == '0)
            begin
                job.data = '0;
                if (!byte_present || text_end)
                begin
                    job.count = CNT_W'(1);
                    push_c    = 1'b1;
                end
            end
            else
            begin
                job.has_bytes = 1'b1;
                job.count     = out_cnt;
                push_c        = 1'b1;
            end
        end
    end

    assign push = in_accept & push_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= '0;
        end
        else if (held_clear)
        begin
            held_cnt_reg <= '0;
        end
        else if (in_accept)
        begin
            held_cnt_reg <= held_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (in_accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sfr_queue.sv */
// Short work queue between the front end and the output sequencer.
// Depends on sfr_pkg for job_t and the queue depth.
`default_nettype none

module sfr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sfr_pkg::job_t din,
    output logic               full,
    output logic               head_valid,
    output sfr_pkg::job_t      head,
    input  wire logic          pop
);
    import sfr_pkg::*;

    job_t [QUEUE_DEPTH-1:0] entries_reg;
    logic [QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]        count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

/* rtl/sfr_back.sv */
// Output sequencer: walks the head queue entry one result beat at a time
// into the output register. Depends on sfr_pkg.
`default_nettype none

module sfr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire sfr_pkg::job_t head,
    output logic               pop,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [7:0]         m_axis_tdata,  // out_byte
    output logic [2:0]         m_axis_tuser,  // out_present, stream_done,
                                              // empty_pattern_error
    output logic               m_axis_tlast   // run_last
);
    import sfr_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic             valid_reg;
    byte_t            byte_reg;
    logic [2:0]       user_reg;
    logic             last_reg;
    logic             last_beat;
    logic             load;

    assign last_beat = ({1'b0, idx_reg} == head.count - 1'b1);
    assign load      = head_valid && (!valid_reg || m_axis_tready);
    assign pop       = load && last_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (m_axis_tready)
                valid_reg <= 1'b0;

            if (load)
                idx_reg <= last_beat ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.data[idx_reg];
            user_reg <= {head.err, head.done & last_beat, head.has_bytes};
            last_reg <= last_beat;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = byte_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

/* rtl/stream_find_replace.sv */
// Streaming find-and-replace: replaces every leftmost, non-overlapping
// occurrence of a configured pattern of up to 8 bytes in a byte stream.
// The input stream beat carries one text byte (tdata), a byte-present flag
// (tuser) and end of text (tlast). Each input beat causes zero to eight
// output beats: a byte in tdata, flags in tuser (byte present, end of
// text, empty-pattern error) and tlast on the last beat of that input.
// Bytes that may begin a match are held back and released when the match
// fails or flushed at end of text. An input beat with no byte, an end of
// text or a zero pattern length always yields at least one output beat.
// The front end classifies one input beat per cycle while the queue has room
// and hands its output beats to a four-entry queue; the back end sends one
// output beat per cycle while tready is high. The first output beat of an
// input is written into the queue and then loaded into the output register.
// Throughput is one input beat per cycle while each yields at most one output
// beat and tready is high; an input causing k output beats sends all k in turn.
// When the receiver stalls, the output register holds its beat and the
// queue absorbs up to four input beats that yield output (beats that yield
// none pass freely) before tready drops.
// Reset empties the queue and the held bytes and loads register defaults
// (pattern length one, empty replacement). Configure only while idle.
`default_nettype none

module stream_find_replace (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,  // text_byte
    input  wire logic                       s_axis_tuser,  // byte_present
    input  wire logic                       s_axis_tlast,  // text_end
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // out_byte
    output logic [2:0]                      m_axis_tuser,  // out_present, stream_done,
                                                           // empty_pattern_error
    output logic                            m_axis_tlast,  // run_last
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic      [sfr_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import sfr_pkg::*;

    cfg_t cfg;
    job_t front_job, head;
    logic held_clear;
    logic in_accept;
    logic push, pop;
    logic q_full, head_valid;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    sfr_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .held_clear (held_clear)
    );

    sfr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .held_clear   (held_clear),
        .in_accept    (in_accept),
        .text_byte    (s_axis_tdata),
        .byte_present (s_axis_tuser),
        .text_end     (s_axis_tlast),
        .push         (push),
        .job          (front_job)
    );

    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .din        (front_job),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    sfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
